FILE: src/rrwl_pkg.sv
package rrwl_pkg;

  localparam int unsigned IdWidthDefault    = 16;
  localparam int unsigned CountWidthDefault = 16;

  localparam int unsigned ActionWidth = 2;
  localparam int unsigned ReqIdWidth  = 16;
  localparam int unsigned ViewWidth   = 16;
  localparam int unsigned StatWidth   = 32;

  typedef enum logic [ActionWidth-1:0] {
    ACT_READ   = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_UNLOCK = 2'd2
  } action_e;

endpackage

FILE: src/recursive_rw_lock_unit_core.sv
// Channel  | Handshake               | Beat fields
// ---------+-------------------------+-------------------------------------------
// request  | in_valid_i / in_ready_o | action_i, requester_id_i
// response | out_valid_o/out_ready_i | granted_o, fault_o, reader_count_o,
//          |                         | write_depth_o, owner_id_o, read_grants_o,
//          |                         | write_grants_o, write_misses_o
//
// One request per cycle while no response is stalled; the response appears the cycle after acceptance.
// Lock state and counters update at acceptance, the response fields read them.
// A stalled response holds; the next request is taken in the same cycle the
// response is taken. Reset clears lock state, counters and out_valid_o.
module recursive_rw_lock_unit_core #(
  parameter int unsigned ID_WIDTH    = rrwl_pkg::IdWidthDefault,
  parameter int unsigned COUNT_WIDTH = rrwl_pkg::CountWidthDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [rrwl_pkg::ActionWidth-1:0] action_i,
  input  logic [rrwl_pkg::ReqIdWidth-1:0]  requester_id_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             granted_o,
  output logic                             fault_o,
  output logic [rrwl_pkg::ViewWidth-1:0]   reader_count_o,
  output logic [rrwl_pkg::ViewWidth-1:0]   write_depth_o,
  output logic [rrwl_pkg::ViewWidth-1:0]   owner_id_o,
  output logic [rrwl_pkg::StatWidth-1:0]   read_grants_o,
  output logic [rrwl_pkg::StatWidth-1:0]   write_grants_o,
  output logic [rrwl_pkg::StatWidth-1:0]   write_misses_o
);
  import rrwl_pkg::*;

  localparam int unsigned IdW = (ID_WIDTH < ReqIdWidth) ? ID_WIDTH : ReqIdWidth;

  logic [COUNT_WIDTH-1:0] readers_q, readers_d;
  logic [COUNT_WIDTH-1:0] level_q, level_d;
  logic [IdW-1:0]         writer_q, writer_d;
  logic [StatWidth-1:0]   rd_grants_q, rd_grants_d;
  logic [StatWidth-1:0]   wr_grants_q, wr_grants_d;
  logic [StatWidth-1:0]   wr_misses_q, wr_misses_d;
  logic                   granted_q, granted_d;
  logic                   fault_q, fault_d;
  logic                   out_valid_q;

  logic [IdW-1:0] req_id;
  logic           in_fire;
  logic           readers_full, level_full, is_owner;
  logic [31:0]    readers_ext, level_ext;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign req_id       = requester_id_i[IdW-1:0];
  assign readers_full = (readers_q == {COUNT_WIDTH{1'b1}});
  assign level_full   = (level_q == {COUNT_WIDTH{1'b1}});
  assign is_owner     = (writer_q == req_id);

  always_comb begin
    readers_d   = readers_q;
    level_d     = level_q;
    writer_d    = writer_q;
    rd_grants_d = rd_grants_q;
    wr_grants_d = wr_grants_q;
    wr_misses_d = wr_misses_q;
    granted_d   = 1'b0;
    fault_d     = 1'b0;
    unique case (action_i)
      ACT_READ: begin
        if (level_q == '0) begin
          if (readers_full) begin
            fault_d = 1'b1;
          end else begin
            readers_d   = readers_q + 1'b1;
            rd_grants_d = rd_grants_q + 1'b1;
            granted_d   = 1'b1;
          end
        end else if (is_owner) begin
          if (level_full) begin
            fault_d = 1'b1;
          end else begin
            level_d     = level_q + 1'b1;
            wr_grants_d = wr_grants_q + 1'b1;
            granted_d   = 1'b1;
          end
        end
      end
      ACT_WRITE: begin
        if (readers_q == '0 && level_q == '0) begin
          level_d     = COUNT_WIDTH'(1);
          writer_d    = req_id;
          wr_grants_d = wr_grants_q + 1'b1;
          granted_d   = 1'b1;
        end else if (readers_q != '0 || !is_owner) begin
          wr_misses_d = wr_misses_q + 1'b1;
        end else if (level_full) begin
          fault_d = 1'b1;
        end else begin
          level_d   = level_q + 1'b1;
          granted_d = 1'b1;
        end
      end
      ACT_UNLOCK: begin
        if (readers_q != '0) begin
          readers_d = readers_q - 1'b1;
          granted_d = 1'b1;
        end else if (level_q != '0 && is_owner) begin
          level_d   = level_q - 1'b1;
          granted_d = 1'b1;
          if (level_q == COUNT_WIDTH'(1)) begin
            writer_d = '0;
          end
        end else begin
          fault_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      readers_q   <= '0;
      level_q     <= '0;
      writer_q    <= '0;
      rd_grants_q <= '0;
      wr_grants_q <= '0;
      wr_misses_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        readers_q   <= readers_d;
        level_q     <= level_d;
        writer_q    <= writer_d;
        rd_grants_q <= rd_grants_d;
        wr_grants_q <= wr_grants_d;
        wr_misses_q <= wr_misses_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      granted_q <= granted_d;
      fault_q   <= fault_d;
    end
  end

  // lock state only moves on a new beat, so it doubles as the response payload
  assign readers_ext    = 32'(readers_q);
  assign level_ext      = 32'(level_q);
  assign out_valid_o    = out_valid_q;
  assign granted_o      = granted_q;
  assign fault_o        = fault_q;
  assign reader_count_o = readers_ext[ViewWidth-1:0];
  assign write_depth_o  = level_ext[ViewWidth-1:0];
  assign owner_id_o     = ViewWidth'(writer_q);
  assign read_grants_o  = rd_grants_q;
  assign write_grants_o = wr_grants_q;
  assign write_misses_o = wr_misses_q;

  a_excl_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(readers_q != '0 && level_q != '0))
    else $error("read and write holds coexist");

  a_owner_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (level_q == '0) |-> (writer_q == '0))
    else $error("owner kept without write hold");

  a_grant_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(granted_o && fault_o))
    else $error("grant and fault together");

  a_read_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && action_i == ACT_READ && level_q == '0 && !readers_full)
      |=> (readers_q == $past(readers_q) + 1'b1) && granted_o)
    else $error("free read not counted");

endmodule

FILE: dv/tb_recursive_rw_lock_unit_core.sv
`timescale 1ns / 100ps

module tb_recursive_rw_lock_unit_core;
  import rrwl_pkg::*;

  localparam int unsigned IdWidth    = IdWidthDefault;
  localparam int unsigned CountWidth = CountWidthDefault;
  localparam logic [CountWidth-1:0] CntMax = '1;
  localparam logic [ReqIdWidth-1:0] IdMask = ReqIdWidth'((33'd1 << IdWidth) - 1);
  localparam logic [ActionWidth-1:0] ActReserved = 2'd3;
  localparam int unsigned RandomItems = 1200;
  localparam int unsigned IdleLimit = 400;

  typedef struct {
    logic [ActionWidth-1:0] act;
    logic [ReqIdWidth-1:0]  id;
    int                     gap;
  } lock_req_t;

  typedef struct {
    logic                 granted;
    logic                 fault;
    logic [ViewWidth-1:0] readers;
    logic [ViewWidth-1:0] depth;
    logic [ViewWidth-1:0] owner;
    logic [StatWidth-1:0] rd_grants;
    logic [StatWidth-1:0] wr_grants;
    logic [StatWidth-1:0] wr_misses;
  } lock_view_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic [ActionWidth-1:0] action_i = ACT_READ;
  logic [ReqIdWidth-1:0]  requester_id_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic                   granted_o;
  logic                   fault_o;
  logic [ViewWidth-1:0]   reader_count_o;
  logic [ViewWidth-1:0]   write_depth_o;
  logic [ViewWidth-1:0]   owner_id_o;
  logic [StatWidth-1:0]   read_grants_o;
  logic [StatWidth-1:0]   write_grants_o;
  logic [StatWidth-1:0]   write_misses_o;

  lock_req_t  pending_reqs[$];
  int         resp_gaps[$];
  lock_view_t due_views[$];

  logic [CountWidth-1:0] rd_holds = '0;
  logic [CountWidth-1:0] wr_depth = '0;
  logic [ReqIdWidth-1:0] wr_owner = '0;
  logic [StatWidth-1:0]  rd_total = '0;
  logic [StatWidth-1:0]  wr_total = '0;
  logic [StatWidth-1:0]  miss_total = '0;

  lock_req_t next_req;
  logic      staged;
  int        tx_wait;
  logic      rx_armed;
  int        rx_wait;
  logic      calm;
  int        planned = 0;
  int        errors = 0;
  int        idle_cycles = 0;

  recursive_rw_lock_unit_core #(
    .ID_WIDTH   (IdWidth),
    .COUNT_WIDTH(CountWidth)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .requester_id_i(requester_id_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .granted_o     (granted_o),
    .fault_o       (fault_o),
    .reader_count_o(reader_count_o),
    .write_depth_o (write_depth_o),
    .owner_id_o    (owner_id_o),
    .read_grants_o (read_grants_o),
    .write_grants_o(write_grants_o),
    .write_misses_o(write_misses_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic lock_view_t apply_request(input logic [ActionWidth-1:0] act,
                                               input logic [ReqIdWidth-1:0] id);
    lock_view_t v;
    logic [ReqIdWidth-1:0] req;
    logic ok;
    logic bad;
    req = id & IdMask;
    ok  = 1'b0;
    bad = 1'b0;
    case (act)
      ACT_READ: begin
        if (wr_depth == '0) begin
          if (rd_holds == CntMax) begin
            bad = 1'b1;
          end else begin
            rd_holds++;
            rd_total++;
            ok = 1'b1;
          end
        end else if (wr_owner == req) begin
          if (wr_depth == CntMax) begin
            bad = 1'b1;
          end else begin
            wr_depth++;
            wr_total++;
            ok = 1'b1;
          end
        end
      end
      ACT_WRITE: begin
        if (rd_holds == '0 && wr_depth == '0) begin
          wr_depth = CountWidth'(1);
          wr_owner = req;
          wr_total++;
          ok = 1'b1;
        end else if (rd_holds != '0) begin
          miss_total++;
        end else if (wr_owner == req) begin
          if (wr_depth == CntMax) begin
            bad = 1'b1;
          end else begin
            wr_depth++;
            ok = 1'b1;
          end
        end else begin
          miss_total++;
        end
      end
      ACT_UNLOCK: begin
        if (rd_holds != '0) begin
          rd_holds--;
          ok = 1'b1;
        end else if (wr_depth != '0) begin
          if (wr_owner == req) begin
            wr_depth--;
            if (wr_depth == '0) wr_owner = '0;
            ok = 1'b1;
          end else begin
            bad = 1'b1;
          end
        end else begin
          bad = 1'b1;
        end
      end
      default: ;
    endcase
    v.granted   = ok;
    v.fault     = bad;
    v.readers   = ViewWidth'(rd_holds);
    v.depth     = ViewWidth'(wr_depth);
    v.owner     = ViewWidth'(wr_owner);
    v.rd_grants = rd_total;
    v.wr_grants = wr_total;
    v.wr_misses = miss_total;
    return v;
  endfunction

  function automatic logic [ReqIdWidth-1:0] pick_id();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2, 3:    return ReqIdWidth'($urandom_range(1, 7));
      default: return ReqIdWidth'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic push_req(input logic [ActionWidth-1:0] act, input logic [ReqIdWidth-1:0] id);
    lock_req_t r;
    r.act = act;
    r.id  = id;
    r.gap = calm ? 0 : int'($urandom_range(0, 11));
    pending_reqs.push_back(r);
    resp_gaps.push_back(calm ? 0 : int'($urandom_range(0, 11)));
    planned++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      action_i       <= ACT_READ;
      requester_id_i <= '0;
      staged = 1'b0;
      tx_wait = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        due_views.push_back(apply_request(action_i, requester_id_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (!staged && pending_reqs.size() > 0) begin
          next_req = pending_reqs.pop_front();
          staged = 1'b1;
          tx_wait = next_req.gap;
        end
        if (staged && tx_wait == 0) begin
          in_valid_i     <= 1'b1;
          action_i       <= next_req.act;
          requester_id_i <= next_req.id;
          staged = 1'b0;
        end else begin
          in_valid_i <= 1'b0;
          if (staged) tx_wait--;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : take_views
    lock_view_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_armed = 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (due_views.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual granted=%0b fault=%0b",
                   $time, granted_o, fault_o);
          errors++;
        end else begin
          want = due_views.pop_front();
          check_field("granted", 32'(want.granted), 32'(granted_o));
          check_field("fault", 32'(want.fault), 32'(fault_o));
          check_field("reader_count", 32'(want.readers), 32'(reader_count_o));
          check_field("write_depth", 32'(want.depth), 32'(write_depth_o));
          check_field("owner_id", 32'(want.owner), 32'(owner_id_o));
          check_field("read_grants", want.rd_grants, read_grants_o);
          check_field("write_grants", want.wr_grants, write_grants_o);
          check_field("write_misses", want.wr_misses, write_misses_o);
        end
        rx_armed = 1'b0;
      end
      if (!rx_armed) begin
        rx_wait = (resp_gaps.size() > 0) ? resp_gaps.pop_front() : 0;
        rx_armed = 1'b1;
      end
      if (rx_wait == 0) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        rx_wait--;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("%0t: no beat for %0d cycles", $time, IdleLimit);
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : run_test
    int n;
    int ops;
    int depth;
    int k;
    int j;
    logic [ReqIdWidth-1:0] owner;
    logic [ReqIdWidth-1:0] other;

    calm = 1'b0;
    push_req(ACT_UNLOCK, 16'h0000);
    push_req(ACT_READ, 16'hFFFF);
    push_req(ACT_WRITE, 16'h0005);
    push_req(ACT_READ, 16'h0000);
    push_req(ACT_UNLOCK, 16'h1234);
    push_req(ACT_UNLOCK, 16'hFFFF);
    push_req(ActReserved, 16'hAAAA);
    push_req(ACT_WRITE, 16'h0000);
    push_req(ACT_READ, 16'h0000);
    push_req(ACT_WRITE, 16'h0000);
    push_req(ACT_READ, 16'h0001);
    push_req(ACT_WRITE, 16'hFFFF);
    push_req(ACT_UNLOCK, 16'hFFFF);
    push_req(ActReserved, 16'h5555);
    push_req(ACT_UNLOCK, 16'h0000);
    push_req(ACT_UNLOCK, 16'h0000);
    push_req(ACT_UNLOCK, 16'h0000);
    push_req(ACT_WRITE, 16'hFFFF);
    push_req(ACT_UNLOCK, 16'h7FFF);
    push_req(ACT_WRITE, 16'h5555);
    push_req(ACT_READ, 16'hAAAA);
    push_req(ACT_UNLOCK, 16'hFFFF);
    push_req(ACT_UNLOCK, 16'hFFFF);

    // mostly well-formed reader and writer sessions, some noise
    n = planned;
    while (planned < n + RandomItems) begin
      calm = ($urandom_range(0, 3) == 0);
      k = $urandom_range(0, 9);
      if (k < 4) begin
        ops = $urandom_range(1, 6);
        for (j = 0; j < ops; j++) push_req(ACT_READ, pick_id());
        if ($urandom_range(0, 1) == 1) push_req(ACT_WRITE, pick_id());
        for (j = 0; j < ops; j++) push_req(ACT_UNLOCK, pick_id());
      end else if (k < 8) begin
        owner = pick_id();
        push_req(ACT_WRITE, owner);
        depth = 1;
        ops = $urandom_range(0, 8);
        for (j = 0; j < ops; j++) begin
          other = owner ^ ReqIdWidth'($urandom_range(1, 65535));
          case ($urandom_range(0, 5))
            0: begin push_req(ACT_READ, owner); depth++; end
            1: begin push_req(ACT_WRITE, owner); depth++; end
            2: push_req(ACT_READ, other);
            3: push_req(ACT_WRITE, other);
            4: push_req(ACT_UNLOCK, other);
            default: begin
              if (depth > 1) begin
                push_req(ACT_UNLOCK, owner);
                depth--;
              end
            end
          endcase
        end
        for (j = 0; j < depth; j++) push_req(ACT_UNLOCK, owner);
      end else begin
        ops = $urandom_range(1, 4);
        for (j = 0; j < ops; j++) begin
          push_req(ActionWidth'($urandom_range(0, 3)), pick_id());
        end
      end
    end

    // release whatever holds remain, back to back but for the last unlock
    calm = 1'b1;
    push_req(ACT_UNLOCK, 16'h0000);
    push_req(ACT_UNLOCK, 16'h0000);
    push_req(ACT_UNLOCK, 16'hFFFF);
    push_req(ACT_UNLOCK, 16'hFFFF);
    for (k = 0; k < 16; k++) push_req(ACT_UNLOCK, pick_id());
    calm = 1'b0;
    push_req(ACT_UNLOCK, owner);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() > 0 || staged || in_valid_i) @(negedge clk_i);
    while (due_views.size() > 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/rrwl_pkg.sv
src/recursive_rw_lock_unit_core.sv
dv/tb_recursive_rw_lock_unit_core.sv
